>>> src/ftfa_pkg.sv
// Package: payload types, state encoding and controller/datapath command structs.
package ftfa_pkg;

  localparam logic [1:0] TransportTcp = 2'd0;
  localparam logic [1:0] TransportUdp = 2'd1;

  localparam int unsigned KeyWidth = 64 * 4 + 32 + 1;

  typedef struct packed {
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [1:0]  transport;
    logic [15:0] frame_length;
    logic [52:0] timestamp_us;
  } in_item_t;

  typedef struct packed {
    logic [8:0]  session_id;
    logic        tracked;
    logic        is_new;
    logic        table_full;
    logic [31:0] packet_count;
    logic [47:0] total_bytes;
    logic [52:0] start_time_us;
    logic [52:0] end_time_us;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle,
    StSearch,
    StCompare,
    StUpdate,
    StOutput
  } state_e;

  typedef struct packed {
    logic load;
    logic search_step;
    logic do_update;
    logic out_valid;
  } ctrl_cmd_t;

  typedef struct packed {
    logic untracked;
    logic search_done;
    logic hit;
    logic out_taken;
  } ctrl_sts_t;

endpackage

>>> src/ftfa_ctrl.sv
// Controller: sequences search, update and output of one packet at a time.
module ftfa_ctrl import ftfa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StSearch;
      end
      StSearch: begin
        if (sts_i.untracked) state_d = StOutput;
        else if (sts_i.search_done) state_d = StUpdate;
        else state_d = StCompare;
      end
      StCompare: begin
        if (sts_i.hit) state_d = StUpdate;
        else state_d = StSearch;
      end
      StUpdate: state_d = StOutput;
      StOutput: begin
        if (sts_i.out_taken) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StCompare: cmd_o.search_step = !sts_i.hit;
      StUpdate: cmd_o.do_update = 1'b1;
      StOutput: cmd_o.out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

>>> src/ftfa_datapath.sv
// Datapath: flow table memories, key compare, counter update and result register.
module ftfa_datapath import ftfa_pkg::*; #(
  parameter int unsigned FlowEntries = 256,
  parameter int unsigned IdxW = (FlowEntries > 1) ? $clog2(FlowEntries) : 1
) (
  input  logic      clk_i,
  input  logic      in_valid_i,
  input  in_item_t  in_data_i,
  input  logic      out_ready_i,
  output out_item_t out_data_o,
  input  ctrl_cmd_t cmd_i,
  output ctrl_sts_t sts_o,
  input  logic      rst_ni
);

  localparam int unsigned CntW = $clog2(FlowEntries + 1);
  localparam logic [CntW-1:0] Full = CntW'(FlowEntries);

  logic [KeyWidth-1:0] key_mem [FlowEntries];
  logic [31:0] pkt_mem [FlowEntries];
  logic [47:0] byte_mem [FlowEntries];
  logic [52:0] start_mem [FlowEntries];

  in_item_t item_q;
  logic [CntW-1:0] used_q, scan_q;
  logic [KeyWidth-1:0] rd_key_q;
  logic [31:0] rd_pkt_q;
  logic [47:0] rd_byte_q;
  logic [52:0] rd_start_q;
  out_item_t res_q, res_d;
  logic [KeyWidth-1:0] key;
  logic [IdxW-1:0] slot;

  assign key = {item_q.src_addr_hi, item_q.src_addr_lo, item_q.dst_addr_hi,
                item_q.dst_addr_lo, item_q.sport, item_q.dport,
                item_q.transport[0]};
  assign slot = scan_q[IdxW-1:0];

  assign sts_o.untracked = item_q.transport[1];
  assign sts_o.search_done = (scan_q == used_q);
  assign sts_o.hit = (rd_key_q == key);
  assign sts_o.out_taken = cmd_i.out_valid && out_ready_i;
  assign out_data_o = res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && in_valid_i) item_q <= in_data_i;
    rd_key_q <= key_mem[slot];
    rd_pkt_q <= pkt_mem[slot];
    rd_byte_q <= byte_mem[slot];
    rd_start_q <= start_mem[slot];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      scan_q <= '0;
    end else begin
      if (cmd_i.load) begin
        scan_q <= '0;
      end else if (cmd_i.search_step) begin
        scan_q <= scan_q + 1'b1;
      end
      if (cmd_i.do_update && scan_q == used_q && used_q != Full) begin
        used_q <= used_q + 1'b1;
      end
    end
  end

  logic fresh;
  logic [31:0] pkt_n;
  logic [48:0] byte_sum;
  logic [47:0] byte_n;
  logic [52:0] start_n;
  logic [CntW:0] sid;

  always_comb begin
    fresh = (scan_q == used_q);
    pkt_n = fresh ? 32'd1 : ((rd_pkt_q == '1) ? rd_pkt_q : rd_pkt_q + 32'd1);
    byte_sum = (fresh ? 49'd0 : {1'b0, rd_byte_q}) + {33'd0, item_q.frame_length};
    byte_n = byte_sum[48] ? '1 : byte_sum[47:0];
    start_n = fresh ? item_q.timestamp_us : rd_start_q;
    sid = {1'b0, scan_q} + 1'b1;
  end

  always_comb begin
    res_d = '0;
    if (fresh && used_q == Full) begin
      res_d.table_full = 1'b1;
    end else begin
      res_d.session_id = 9'(sid);
      res_d.tracked = 1'b1;
      res_d.is_new = fresh;
      res_d.packet_count = pkt_n;
      res_d.total_bytes = byte_n;
      res_d.start_time_us = start_n;
      res_d.end_time_us = item_q.timestamp_us;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_update && !(fresh && used_q == Full)) begin
      pkt_mem[slot] <= pkt_n;
      byte_mem[slot] <= byte_n;
      start_mem[slot] <= start_n;
      if (fresh) key_mem[slot] <= key;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_q <= '0;
    end else if (cmd_i.do_update) begin
      res_q <= res_d;
    end
  end

endmodule

>>> src/five_tuple_flow_accounting_unit.sv
// Top level: flow accounting unit, controller plus datapath.
// One packet at a time. An untracked packet goes straight from search to output; a tracked one
// scans the allocated entries in order, alternating search and compare states through the
// registered table read, then updates and waits for the output to be taken. Entries are
// table memories with no clearing pass; allocation fills slots in order.
module five_tuple_flow_accounting_unit import ftfa_pkg::*; #(
  parameter int unsigned FLOW_ENTRIES = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  ftfa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .sts_i(sts), .cmd_o(cmd)
  );

  ftfa_datapath #(.FlowEntries(FLOW_ENTRIES)) u_dp (
    .clk_i, .in_valid_i, .in_data_i, .out_ready_i, .out_data_o,
    .cmd_i(cmd), .sts_o(sts), .rst_ni
  );

  assign out_valid_o = cmd.out_valid;

endmodule

>>> src/ftfa_checker.sv
// Port-level checker for the flow accounting unit, with its bind.
module ftfa_checker import ftfa_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken twice");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while result pending");

  a_full_untracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.table_full |-> !out_data_o.tracked &&
      out_data_o.session_id == '0)
    else $error("full result is tracked");

endmodule

bind five_tuple_flow_accounting_unit ftfa_checker u_ftfa_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);

>>> sim/tb_five_tuple_flow_accounting_unit.sv
// Testbench for the five-tuple flow accounting unit against a flow table predictor.
module tb_five_tuple_flow_accounting_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import ftfa_pkg::*;

  localparam int unsigned NumFlows = 256;
  localparam int unsigned IdleLimit = 20000;
  localparam logic [1:0] TransportOther = 2'd2;
  localparam logic [1:0] TransportRsvd = 2'd3;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;

  five_tuple_flow_accounting_unit #(.FLOW_ENTRIES(NumFlows)) dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o(out_data)
  );

  // predictor copy of the flow table
  in_item_t flow_key[NumFlows];
  logic [31:0] flow_pkts[NumFlows];
  logic [47:0] flow_octets[NumFlows];
  logic [52:0] flow_first[NumFlows];
  logic [52:0] flow_latest[NumFlows];
  int unsigned flows_alloc;

  out_item_t pending_q[$];
  int unsigned fail_cnt;
  int unsigned sent_cnt;
  int unsigned got_cnt;
  int unsigned full_cnt;
  int unsigned idle_cycles;
  int unsigned hold_off;
  bit burst_gaps;

  // pool of keys for reuse
  in_item_t key_pool[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit same_flow(in_item_t a, in_item_t b);
    return a.src_addr_hi == b.src_addr_hi && a.src_addr_lo == b.src_addr_lo &&
           a.dst_addr_hi == b.dst_addr_hi && a.dst_addr_lo == b.dst_addr_lo &&
           a.sport == b.sport && a.dport == b.dport &&
           a.transport == b.transport;
  endfunction

  function automatic out_item_t account_packet(in_item_t pkt);
    out_item_t res;
    int slot;
    bit fresh;
    res = '0;
    slot = -1;
    fresh = 1'b0;
    if (pkt.transport != TransportTcp && pkt.transport != TransportUdp) return res;
    for (int i = 0; i < flows_alloc; i++) begin
      if (same_flow(flow_key[i], pkt)) begin
        slot = i;
        break;
      end
    end
    if (slot < 0) begin
      if (flows_alloc >= NumFlows) begin
        res.table_full = 1'b1;
        return res;
      end
      slot = flows_alloc;
      flows_alloc++;
      flow_key[slot] = pkt;
      flow_pkts[slot] = '0;
      flow_octets[slot] = '0;
      flow_first[slot] = pkt.timestamp_us;
      fresh = 1'b1;
    end
    flow_latest[slot] = pkt.timestamp_us;
    if (flow_pkts[slot] != 32'hFFFF_FFFF) flow_pkts[slot]++;
    if ({1'b0, flow_octets[slot]} + pkt.frame_length > 49'h0_FFFF_FFFF_FFFF)
      flow_octets[slot] = 48'hFFFF_FFFF_FFFF;
    else
      flow_octets[slot] = flow_octets[slot] + pkt.frame_length;
    res.session_id = 9'(slot + 1);
    res.tracked = 1'b1;
    res.is_new = fresh;
    res.packet_count = flow_pkts[slot];
    res.total_bytes = flow_octets[slot];
    res.start_time_us = flow_first[slot];
    res.end_time_us = flow_latest[slot];
    return res;
  endfunction

  task automatic send_packet(in_item_t pkt);
    if (burst_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= pkt;
    do @(posedge clk); while (!in_ready);
    pending_q = {pending_q, account_packet(pkt)};
    sent_cnt++;
    if (pkt.transport == TransportTcp || pkt.transport == TransportUdp) begin
      key_pool = {key_pool, pkt};
    end
  endtask

  function automatic in_item_t random_packet();
    in_item_t p;
    p.src_addr_hi = {$urandom, $urandom};
    p.src_addr_lo = {$urandom, $urandom};
    p.dst_addr_hi = {$urandom, $urandom};
    p.dst_addr_lo = {$urandom, $urandom};
    p.sport = 16'($urandom);
    p.dport = 16'($urandom);
    p.frame_length = 16'($urandom);
    p.timestamp_us = 53'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: begin
        p.src_addr_hi = '0;
        p.dst_addr_hi = '0;
        p.src_addr_lo[63:32] = '0;
        p.dst_addr_lo[63:32] = '0;
      end
      default: ;
    endcase
    p.transport = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                               : 2'($urandom_range(0, 1));
    return p;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      got_cnt++;
      if (pending_q.size() == 0) begin
        $error("unexpected result transfer %p", out_data);
        fail_cnt++;
      end else begin
        exp_r = pending_q.pop_front();
        if (exp_r.table_full) full_cnt++;
        if (out_data.session_id !== exp_r.session_id) begin
          $error("session_id exp %0d got %0d", exp_r.session_id, out_data.session_id);
          fail_cnt++;
        end
        if (out_data.tracked !== exp_r.tracked) begin
          $error("tracked exp %0d got %0d", exp_r.tracked, out_data.tracked);
          fail_cnt++;
        end
        if (out_data.is_new !== exp_r.is_new) begin
          $error("is_new exp %0d got %0d", exp_r.is_new, out_data.is_new);
          fail_cnt++;
        end
        if (out_data.table_full !== exp_r.table_full) begin
          $error("table_full exp %0d got %0d", exp_r.table_full, out_data.table_full);
          fail_cnt++;
        end
        if (out_data.packet_count !== exp_r.packet_count) begin
          $error("packet_count exp %0d got %0d", exp_r.packet_count, out_data.packet_count);
          fail_cnt++;
        end
        if (out_data.total_bytes !== exp_r.total_bytes) begin
          $error("total_bytes exp %0d got %0d", exp_r.total_bytes, out_data.total_bytes);
          fail_cnt++;
        end
        if (out_data.start_time_us !== exp_r.start_time_us) begin
          $error("start_time_us exp %0d got %0d", exp_r.start_time_us, out_data.start_time_us);
          fail_cnt++;
        end
        if (out_data.end_time_us !== exp_r.end_time_us) begin
          $error("end_time_us exp %0d got %0d", exp_r.end_time_us, out_data.end_time_us);
          fail_cnt++;
        end
      end
    end
  end

  // receiver stall pattern, with an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off != 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (burst_gaps) begin
      out_ready <= ($urandom_range(0, 2) != 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no transfer for %0d cycles", IdleLimit);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic test_directed_edges();
    in_item_t p;
    p = '1;
    p.transport = TransportTcp;
    p.timestamp_us = '1;
    send_packet(p);
    send_packet(p);
    p.transport = TransportUdp;
    p.timestamp_us = '0;
    send_packet(p);
    p = '0;
    p.transport = TransportTcp;
    send_packet(p);
    p.frame_length = 16'hFFFF;
    send_packet(p);
    p.transport = TransportOther;
    send_packet(p);
    p.transport = TransportRsvd;
    p.sport = 16'hFFFF;
    send_packet(p);
    p = '0;
    p.sport = 16'h1;
    p.transport = TransportUdp;
    send_packet(p);
    p.sport = 16'h0;
    p.dport = 16'h1;
    send_packet(p);
    p.src_addr_lo = 64'h1;
    send_packet(p);
    wait_drained();
  endtask

  task automatic test_random_traffic(int unsigned n);
    in_item_t p;
    for (int unsigned k = 0; k < n; k++) begin
      if (key_pool.size() != 0 && $urandom_range(0, 9) < 6) begin
        p = key_pool[$urandom_range(0, key_pool.size() - 1)];
        p.frame_length = 16'($urandom);
        p.timestamp_us = 53'({$urandom, $urandom});
        if ($urandom_range(0, 19) == 0) p.sport ^= 16'(1 << $urandom_range(0, 15));
      end else begin
        p = random_packet();
      end
      send_packet(p);
    end
  endtask

  task automatic test_backpressure();
    hold_off <= 400;
    for (int k = 0; k < 6; k++) send_packet(random_packet());
    wait_drained();
  endtask

  task automatic test_table_full();
    in_item_t p;
    while (flows_alloc < NumFlows) begin
      p = random_packet();
      p.transport = 2'($urandom_range(0, 1));
      send_packet(p);
    end
    for (int k = 0; k < 30; k++) begin
      p = ($urandom_range(0, 1) != 0) ? random_packet() :
          key_pool[$urandom_range(0, key_pool.size() - 1)];
      send_packet(p);
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    hold_off = 0;
    burst_gaps = 1'b0;
    flows_alloc = 0;
    fail_cnt = 0;
    sent_cnt = 0;
    got_cnt = 0;
    full_cnt = 0;
    idle_cycles = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    burst_gaps = 1'b1;
    test_random_traffic(850);
    test_backpressure();
    burst_gaps = 1'b0;
    test_random_traffic(200);
    burst_gaps = 1'b1;
    test_table_full();
    test_random_traffic(350);
    wait_drained();
    repeat (600) @(posedge clk);
    $display("sent %0d packets, checked %0d results", sent_cnt, got_cnt);
    $display("%0d flows allocated, %0d table-full results", flows_alloc, full_cnt);
    if (fail_cnt == 0 && pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
